// File: rtl/olst_pkg.sv
// olst_pkg: shared constants, operation codes and memory request type for
// the ordered list store. No dependencies.
`default_nettype none

package olst_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_PREPEND  = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_CONTAINS = 2'd3
    } t_op;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: rtl/olst_store.sv
// olst_store: entry memory, one write port and one read port with
// registered read data. Depends on olst_pkg.
`default_nettype none

module olst_store
    import olst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mem_req          i_req,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/olst_seq.sv
// olst_seq: sequencer with the shared compare unit; walks the entry memory
// for search and shifts, and holds the result register. Depends on olst_pkg.
`default_nettype none

module olst_seq
    import olst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [WORD_W-1:0] i_value,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_found,
    output logic                   o_full_res,
    output logic      [CNT_W-1:0]  o_entry_count,
    output t_mem_req               o_mem_req,
    input  wire logic [WORD_W-1:0] i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_MOVE,
        S_HEAD,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [WORD_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cidx, n_cidx;
    logic [IDX_W-1:0]  r_dst, n_dst;
    logic              r_issue, n_issue;
    logic              r_pend, n_pend;
    logic              r_up, n_up;
    logic              r_found, n_found;
    logic              r_full, n_full;
    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    logic              r_out_full, n_out_full;
    logic [CNT_W-1:0]  r_out_count, n_out_count;
    t_mem_req          req;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_used      = r_used;
        n_idx       = r_idx;
        n_cidx      = r_cidx;
        n_dst       = r_dst;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_up        = r_up;
        n_found     = r_found;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_full  = r_out_full;
        n_out_count = r_out_count;
        req         = '0;
        req.raddr   = r_idx[IDX_W-1:0];

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = t_op'(i_op);
                    n_val   = i_value;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    n_pend  = 1'b0;
                    case (t_op'(i_op))
                        OP_APPEND, OP_PREPEND: begin
                            if (r_used == CNT_W'(DEPTH)) begin
                                n_full  = 1'b1;
                                n_state = S_DONE;
                            end else if (t_op'(i_op) == OP_APPEND || r_used == '0) begin
                                req.we    = 1'b1;
                                req.waddr = r_used[IDX_W-1:0];
                                req.wdata = i_value;
                                n_used    = r_used + CNT_W'(1);
                                n_state   = S_DONE;
                            end else begin
                                n_idx   = r_used - CNT_W'(1);
                                n_issue = 1'b1;
                                n_up    = 1'b1;
                                n_state = S_MOVE;
                            end
                        end
                        default: begin
                            if (r_used == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_idx   = '0;
                                n_issue = 1'b1;
                                n_state = S_SRCH;
                            end
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (r_issue) begin
                    n_pend = 1'b1;
                    n_cidx = r_idx;
                    if (r_idx == r_used - CNT_W'(1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (i_rdata == r_val) begin
                        n_found = 1'b1;
                        if (r_op == OP_REMOVE && r_cidx + CNT_W'(1) != r_used) begin
                            n_idx   = r_cidx + CNT_W'(1);
                            n_issue = 1'b1;
                            n_pend  = 1'b0;
                            n_up    = 1'b0;
                            n_state = S_MOVE;
                        end else begin
                            if (r_op == OP_REMOVE) begin
                                n_used = r_used - CNT_W'(1);
                            end
                            n_state = S_DONE;
                        end
                    end else if (r_cidx == r_used - CNT_W'(1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOVE: begin
                if (r_pend) begin
                    req.we    = 1'b1;
                    req.waddr = r_dst;
                    req.wdata = i_rdata;
                end
                if (r_issue) begin
                    n_pend = 1'b1;
                    n_dst  = r_up ? IDX_W'(r_idx + CNT_W'(1)) : IDX_W'(r_idx - CNT_W'(1));
                    if (r_up ? (r_idx == '0) : (r_idx == r_used - CNT_W'(1))) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_up ? r_idx - CNT_W'(1) : r_idx + CNT_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (r_up) begin
                        n_state = S_HEAD;
                    end else begin
                        n_used  = r_used - CNT_W'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_HEAD: begin
                req.we    = 1'b1;
                req.waddr = '0;
                req.wdata = r_val;
                n_used    = r_used + CNT_W'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_full  = r_full;
                    n_out_count = r_used;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_cidx      <= n_cidx;
        r_dst       <= n_dst;
        r_up        <= n_up;
        r_found     <= n_found;
        r_full      <= n_full;
        r_out_found <= n_out_found;
        r_out_full  <= n_out_full;
        r_out_count <= n_out_count;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_full_res    = r_out_full;
    assign o_entry_count = r_out_count;
    assign o_mem_req     = req;

endmodule

`default_nettype wire

// File: rtl/ordered_list_store.sv
// Ordered list store: append, prepend, remove-first-match and contains.
// Append, a dropped insert, prepend of an empty list and a search of an empty
// list go straight to the result; contains and remove walk the list through the one
// read port, remove then shifts later entries down; prepend shifts every entry up.
// One transaction in flight; the next is taken the cycle after the result loads.
// Reset empties the list (count to zero); entry storage is not cleared.
`default_nettype none

module ordered_list_store
    import olst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic signed [WORD_W-1:0] i_value,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_found,
    output logic                   o_full_res,
    output logic      [CNT_W-1:0]  o_entry_count
);

    t_mem_req          mem_req;
    logic [WORD_W-1:0] mem_rdata;

    olst_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_full_res    (o_full_res),
        .o_entry_count (o_entry_count),
        .o_mem_req     (mem_req),
        .i_rdata       (mem_rdata)
    );

    olst_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/ordered_list_store_chk.sv
// ordered_list_store_chk: port-level checks on the list store, bound to the
// top level. Depends on olst_pkg.
`default_nettype none

module ordered_list_store_chk
    import olst_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic              o_found,
    input wire logic              o_full_res,
    input wire logic [CNT_W-1:0]  o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found) && $stable(o_full_res)
            && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted transaction did not make the block busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_found && o_full_res))
        else $error("found and full both set");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_res |-> o_entry_count == CNT_W'(DEPTH))
        else $error("insert dropped while list not full");

endmodule

bind ordered_list_store ordered_list_store_chk u_chk (.*);

`default_nettype wire

// File: tb/sv/tb_ordered_list_store.sv
`timescale 1ns / 1ps
// tb_ordered_list_store: self-checking testbench for the ordered list store.
// Runs a directed table, then weighted random list operations under several idling phases,
// checking each result against a typed table outcome or a list model held here. Needs olst_pkg, ordered_list_store.

module tb_ordered_list_store;
    import olst_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    typedef struct packed {
        logic             found;
        logic             full_res;
        logic [CNT_W-1:0] entry_count;
    } t_list_outcome;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] value;
        int                reps;
        bit                typed;
        t_list_outcome     outcome;
    } t_directed_row;

    localparam int N_ROWS = 17;
    localparam t_directed_row DIRECTED_ROWS [N_ROWS] = '{
        '{OP_CONTAINS, 32'h0000_0005, 1, 1'b1, '{1'b0, 1'b0, CNT_W'(0)}},
        '{OP_REMOVE,   32'h0000_0005, 1, 1'b1, '{1'b0, 1'b0, CNT_W'(0)}},
        '{OP_APPEND,   32'h8000_0000, 1, 1'b1, '{1'b0, 1'b0, CNT_W'(1)}},
        '{OP_CONTAINS, 32'h8000_0000, 1, 1'b1, '{1'b1, 1'b0, CNT_W'(1)}},
        '{OP_REMOVE,   32'h8000_0000, 1, 1'b1, '{1'b1, 1'b0, CNT_W'(0)}},
        '{OP_PREPEND,  32'h7FFF_FFFF, 1, 1'b1, '{1'b0, 1'b0, CNT_W'(1)}},
        '{OP_APPEND,   32'h7FFF_FFFF, 1, 1'b1, '{1'b0, 1'b0, CNT_W'(2)}},
        '{OP_PREPEND,  32'h0000_0000, 1, 1'b1, '{1'b0, 1'b0, CNT_W'(3)}},
        '{OP_APPEND,   32'hFFFF_FFFF, 1, 1'b1, '{1'b0, 1'b0, CNT_W'(4)}},
        '{OP_REMOVE,   32'h7FFF_FFFF, 1, 1'b0, '0},
        '{OP_REMOVE,   32'h1234_5678, 1, 1'b0, '0},
        '{OP_APPEND,   32'hA5A5_A5A0, 13, 1'b0, '0},
        '{OP_APPEND,   32'h0000_0001, 1, 1'b1, '{1'b0, 1'b1, CNT_W'(DEPTH)}},
        '{OP_PREPEND,  32'h0000_0002, 1, 1'b1, '{1'b0, 1'b1, CNT_W'(DEPTH)}},
        '{OP_REMOVE,   32'hFFFF_FFFF, 1, 1'b0, '0},
        '{OP_REMOVE,   32'hA5A5_A5AC, 1, 1'b0, '0},
        '{OP_CONTAINS, 32'h0000_0000, 1, 1'b0, '0}
    };

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic [1:0]               i_op = OP_APPEND;
    logic signed [WORD_W-1:0] i_value = '0;
    logic                     i_stall = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic                     o_found;
    logic                     o_full_res;
    logic [CNT_W-1:0]         o_entry_count;

    t_phase phase = PH_FREE;
    int     send_idle_pct;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    int     idle_cycles = 0;
    int     failures = 0;

    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_used = 0;
    t_list_outcome     outcomes_due [$];

    ordered_list_store u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_full_res    (o_full_res),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_list_outcome apply_to_list(t_op op, logic [WORD_W-1:0] v);
        t_list_outcome res;
        int            i;
        int            hit;
        res = '0;
        hit = -1;
        if (op == OP_APPEND || op == OP_PREPEND) begin
            if (list_used >= DEPTH) begin
                res.full_res = 1'b1;
            end else if (op == OP_APPEND) begin
                list_words[list_used] = v;
                list_used++;
            end else begin
                for (i = list_used; i > 0; i--)
                    list_words[i] = list_words[i-1];
                list_words[0] = v;
                list_used++;
            end
        end else begin
            for (i = 0; i < list_used && hit < 0; i++)
                if (list_words[i] == v)
                    hit = i;
            if (hit >= 0) begin
                res.found = 1'b1;
                if (op == OP_REMOVE) begin
                    for (i = hit; i + 1 < list_used; i++)
                        list_words[i] = list_words[i+1];
                    list_used--;
                end
            end
        end
        res.entry_count = CNT_W'(list_used);
        return res;
    endfunction

    task automatic offer(input t_op op, input logic [WORD_W-1:0] v, input bit typed,
                         input t_list_outcome typed_res);
        t_list_outcome predicted;
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        predicted = apply_to_list(op, v);
        outcomes_due.push_back(typed ? typed_res : predicted);
    endtask

    // receiver: stalls per phase, one long hold-off in the pressure phase
    always @(posedge i_clk) begin
        t_list_outcome got;
        t_list_outcome want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_found, o_full_res, o_entry_count};
                if (outcomes_due.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: result with nothing outstanding: found=%b full=%b count=%0d",
                                 $realtime, got.found, got.full_res, got.entry_count);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.found !== want.found || got.full_res !== want.full_res
                            || got.entry_count !== want.entry_count) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("%0t: mismatch: found %b/%b full %b/%b count %0d/%0d (exp/act)",
                                     $realtime, want.found, got.found, want.full_res,
                                     got.full_res, want.entry_count, got.entry_count);
                    end
                end
            end
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (phase == PH_PRESSURE && !hold_done) begin
                i_stall   <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
            end else if (phase == PH_RECV_STALL) begin
                i_stall <= ($urandom_range(99, 0) < 80);
            end else if (phase == PH_BOTH) begin
                i_stall <= ($urandom_range(99, 0) < 25);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int                row;
        int                k;
        int                p;
        int                sel;
        bit                filling;
        t_op               op;
        logic [WORD_W-1:0] v;
        t_phase            next_phase;

        filling = 1'b1;
        send_idle_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++)
            for (k = 0; k < DIRECTED_ROWS[row].reps; k++)
                offer(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].value + WORD_W'(k),
                      DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].outcome);

        for (p = 0; p < 5; p++) begin
            next_phase = t_phase'(p);
            phase <= next_phase;
            send_idle_pct = (next_phase == PH_SEND_IDLE) ? 80 :
                            (next_phase == PH_BOTH) ? 25 : 0;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // swing between filling and draining so both full and empty lists recur
                if (list_used == DEPTH && $urandom_range(3, 0) == 0)
                    filling = 1'b0;
                else if (list_used == 0 && $urandom_range(3, 0) == 0)
                    filling = 1'b1;
                else if ($urandom_range(99, 0) < 3)
                    filling = ~filling;
                sel = $urandom_range(99, 0);
                if (sel < (filling ? 60 : 20))
                    op = $urandom_range(1, 0) ? OP_PREPEND : OP_APPEND;
                else if (sel < (filling ? 80 : 45))
                    op = OP_CONTAINS;
                else
                    op = OP_REMOVE;
                sel = $urandom_range(99, 0);
                if (list_used != 0 && sel < 45)
                    v = list_words[$urandom_range(list_used - 1, 0)];
                else if (sel < 75)
                    v = WORD_W'($urandom_range(7, 0)) - 32'd4;
                else
                    v = $urandom;
                offer(op, v, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        phase   <= PH_FREE;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && outcomes_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
